// ===== sv/sdpa_pkg.sv =====
// Shared types, constants and helper functions for the attention block.
// No dependencies; every other file imports this package.
package sdpa_pkg;

   localparam int CMD_W  = 2;
   localparam int ROW_W  = 2;
   localparam int COL_W  = 3;
   localparam int ELEM_W = 16;
   localparam int IDX_W  = 4;   // counters, wide enough for 16 rows or columns

   localparam int DACC_W = 36;  // exact dot product of up to 16 terms
   localparam int MACC_W = 38;  // exact weighted value sum of up to 16 terms
   localparam int SUM_W  = 21;  // sum of up to 16 exp values of 2^16
   localparam int EXP_W  = 17;  // exp value, Q1.16 up to 1.0
   localparam int T_W    = 34;  // base-2 exponent, Q18.16
   localparam int DIV_STEPS = 33;

   localparam logic [16:0] LOG2E_Q16 = 17'd94548;

   typedef enum logic [CMD_W-1:0] {
      OP_LOAD_Q  = 2'd0,
      OP_LOAD_K  = 2'd1,
      OP_LOAD_V  = 2'd2,
      OP_COMPUTE = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_NONE      = 4'd0,
      ST_LOAD      = 4'd1,
      ST_DOT_RD    = 4'd2,
      ST_DOT_MUL   = 4'd3,
      ST_DOT_ACC   = 4'd4,
      ST_SCALE     = 4'd5,
      ST_SCORE     = 4'd6,
      ST_EXP_T     = 4'd7,
      ST_EXP_LO    = 4'd8,
      ST_EXP_HI    = 4'd9,
      ST_DIV_START = 4'd10,
      ST_WGT       = 4'd11,
      ST_MIX_RD    = 4'd12,
      ST_MIX_MUL   = 4'd13,
      ST_MIX_ACC   = 4'd14,
      ST_EMIT      = 4'd15
   } step_type;

   typedef struct packed {
      step_type         step;
      logic [IDX_W-1:0] i;
      logic [IDX_W-1:0] j;
      logic [IDX_W-1:0] k;
      logic             first;      // first term of a running sum or maximum
      logic             last_elem;  // final element of the output matrix
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_busy;
   } status_type;

   // 2^(-idx/16) in Q1.16
   function automatic logic [16:0] exp2_lut(input logic [4:0] idx);
      logic [16:0] v;
      case (idx)
         5'd0:  v = 17'd65536;
         5'd1:  v = 17'd62757;
         5'd2:  v = 17'd60097;
         5'd3:  v = 17'd57549;
         5'd4:  v = 17'd55109;
         5'd5:  v = 17'd52773;
         5'd6:  v = 17'd50535;
         5'd7:  v = 17'd48393;
         5'd8:  v = 17'd46341;
         5'd9:  v = 17'd44376;
         5'd10: v = 17'd42495;
         5'd11: v = 17'd40693;
         5'd12: v = 17'd38968;
         5'd13: v = 17'd37316;
         5'd14: v = 17'd35734;
         5'd15: v = 17'd34219;
         5'd16: v = 17'd32768;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   // integer square root, used at elaboration only
   function automatic longint unsigned isqrt_const(input longint unsigned v);
      longint unsigned rem;
      longint unsigned root;
      longint unsigned bitv;
      rem  = v;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

endpackage

// ===== sv/sdpa_req_if.sv =====
// Request channel: load and compute beats.
// Depends on sdpa_pkg.
interface sdpa_req_if import sdpa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [ROW_W-1:0]   row;
   logic [COL_W-1:0]   column;
   logic signed [ELEM_W-1:0] element;

   modport source (output valid, command, row, column, element, input ready);
   modport sink   (input valid, command, row, column, element, output ready);
endinterface

// ===== sv/sdpa_rsp_if.sv =====
// Response channel: one beat per output matrix element.
// Depends on sdpa_pkg.
interface sdpa_rsp_if import sdpa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ROW_W-1:0]   out_row;
   logic [COL_W-1:0]   out_column;
   logic signed [ELEM_W-1:0] result;
   logic               last;

   modport source (output valid, out_row, out_column, result, last, input ready);
   modport sink   (input valid, out_row, out_column, result, last, output ready);
endinterface

// ===== sv/sdpa_ctrl.sv =====
// Sequencer: walks query rows, key rows and features, issuing datapath steps.
// Depends on sdpa_pkg.
module sdpa_ctrl import sdpa_pkg::*; #(
   parameter int SEQ_POSITIONS = 4,
   parameter int FEATURE_DIM   = 5
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [CMD_W-1:0] req_command,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [IDX_W-1:0] LAST_POS  = IDX_W'(SEQ_POSITIONS - 1);
   localparam logic [IDX_W-1:0] LAST_FEAT = IDX_W'(FEATURE_DIM - 1);

   typedef enum logic [15:0] {
      S_IDLE    = 16'h0001,
      S_DOT_RD  = 16'h0002,
      S_DOT_MUL = 16'h0004,
      S_DOT_ACC = 16'h0008,
      S_SCALE   = 16'h0010,
      S_SCORE   = 16'h0020,
      S_EXP_T   = 16'h0040,
      S_EXP_LO  = 16'h0080,
      S_EXP_HI  = 16'h0100,
      S_DIV_GO  = 16'h0200,
      S_DIV     = 16'h0400,
      S_WGT     = 16'h0800,
      S_MIX_RD  = 16'h1000,
      S_MIX_MUL = 16'h2000,
      S_MIX_ACC = 16'h4000,
      S_EMIT    = 16'h8000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      cmd.step      = ST_NONE;
      cmd.i         = i_ff;
      cmd.j         = j_ff;
      cmd.k         = k_ff;
      cmd.first     = 1'b0;
      cmd.last_elem = (i_ff == LAST_POS) && (k_ff == LAST_FEAT);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (op_type'(req_command) == OP_COMPUTE) begin
                  i_in = '0;
                  j_in = '0;
                  k_in = '0;
                  state_in = S_DOT_RD;
               end else begin
                  cmd.step = ST_LOAD;
               end
            end
         end
         S_DOT_RD: begin
            cmd.step = ST_DOT_RD;
            state_in = S_DOT_MUL;
         end
         S_DOT_MUL: begin
            cmd.step = ST_DOT_MUL;
            state_in = S_DOT_ACC;
         end
         S_DOT_ACC: begin
            cmd.step  = ST_DOT_ACC;
            cmd.first = (k_ff == '0);
            if (k_ff == LAST_FEAT) begin
               k_in = '0;
               state_in = S_SCALE;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = S_DOT_RD;
            end
         end
         S_SCALE: begin
            cmd.step = ST_SCALE;
            state_in = S_SCORE;
         end
         S_SCORE: begin
            cmd.step  = ST_SCORE;
            cmd.first = (j_ff == '0);
            if (j_ff == LAST_POS) begin
               j_in = '0;
               state_in = S_EXP_T;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_DOT_RD;
            end
         end
         S_EXP_T: begin
            cmd.step = ST_EXP_T;
            state_in = S_EXP_LO;
         end
         S_EXP_LO: begin
            cmd.step = ST_EXP_LO;
            state_in = S_EXP_HI;
         end
         S_EXP_HI: begin
            cmd.step  = ST_EXP_HI;
            cmd.first = (j_ff == '0);
            if (j_ff == LAST_POS) begin
               j_in = '0;
               state_in = S_DIV_GO;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_EXP_T;
            end
         end
         S_DIV_GO: begin
            cmd.step = ST_DIV_START;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) state_in = S_WGT;
         end
         S_WGT: begin
            cmd.step = ST_WGT;
            if (j_ff == LAST_POS) begin
               j_in = '0;
               state_in = S_MIX_RD;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_MIX_RD: begin
            cmd.step = ST_MIX_RD;
            state_in = S_MIX_MUL;
         end
         S_MIX_MUL: begin
            cmd.step = ST_MIX_MUL;
            state_in = S_MIX_ACC;
         end
         S_MIX_ACC: begin
            cmd.step  = ST_MIX_ACC;
            cmd.first = (j_ff == '0);
            if (j_ff == LAST_POS) begin
               j_in = '0;
               state_in = S_EMIT;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_MIX_RD;
            end
         end
         S_EMIT: begin
            if (!status.out_busy) begin
               cmd.step = ST_EMIT;
               if (k_ff == LAST_FEAT) begin
                  k_in = '0;
                  if (i_ff == LAST_POS) begin
                     i_in = '0;
                     state_in = S_IDLE;
                  end else begin
                     i_in = i_ff + 1'b1;
                     state_in = S_DOT_RD;
                  end
               end else begin
                  k_in = k_ff + 1'b1;
                  state_in = S_MIX_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/sdpa_datapath.sv =====
// Matrix stores, multiply/accumulate, exp, reciprocal and output register.
// Depends on sdpa_pkg; steered by cmd_type from sdpa_ctrl.
module sdpa_datapath import sdpa_pkg::*; #(
   parameter int SEQ_POSITIONS = 4,
   parameter int FEATURE_DIM   = 5
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [ROW_W-1:0]  req_row,
   input  logic [COL_W-1:0]  req_column,
   input  logic signed [ELEM_W-1:0] req_element,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [ROW_W-1:0]  rsp_out_row,
   output logic [COL_W-1:0]  rsp_out_column,
   output logic signed [ELEM_W-1:0] rsp_result,
   output logic              rsp_last
);

   localparam int DEPTH = SEQ_POSITIONS * FEATURE_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = (SEQ_POSITIONS > 1) ? $clog2(SEQ_POSITIONS) : 1;
   localparam longint unsigned QUOT    = (64'd1 << 32) / FEATURE_DIM;
   localparam longint unsigned INV_RAW = isqrt_const(QUOT);
   localparam logic [16:0] INV = 17'(INV_RAW);

   // stores
   logic signed [ELEM_W-1:0] qmem [DEPTH];
   logic signed [ELEM_W-1:0] kmem [DEPTH];
   logic signed [ELEM_W-1:0] vmem [DEPTH];
   logic signed [ELEM_W-1:0] q_rd_ff, k_rd_ff, v_rd_ff;

   logic [AW-1:0] wr_addr, q_addr, kv_addr;
   logic          wr_ok;

   assign wr_ok   = (32'(req_row) < SEQ_POSITIONS) && (32'(req_column) < FEATURE_DIM);
   assign wr_addr = AW'(32'(req_row) * FEATURE_DIM + 32'(req_column));
   assign q_addr  = AW'(32'(cmd.i) * FEATURE_DIM + 32'(cmd.k));
   assign kv_addr = AW'(32'(cmd.j) * FEATURE_DIM + 32'(cmd.k));

   always_ff @(posedge clock) begin
      if (cmd.step == ST_LOAD && wr_ok) begin
         case (op_type'(req_command))
            OP_LOAD_Q: qmem[wr_addr] <= req_element;
            OP_LOAD_K: kmem[wr_addr] <= req_element;
            OP_LOAD_V: vmem[wr_addr] <= req_element;
            default: ;
         endcase
      end
      q_rd_ff <= qmem[q_addr];
      k_rd_ff <= kmem[kv_addr];
      v_rd_ff <= vmem[kv_addr];
   end

   // score path
   logic signed [31:0]       dot_prod_ff;
   logic signed [DACC_W-1:0] dot_acc_ff;
   logic signed [49:0]       scaled_ff;
   logic signed [31:0]       score_ff [SEQ_POSITIONS];
   logic signed [31:0]       max_ff;
   logic signed [31:0]       acc_sat, score_new;
   logic signed [33:0]       scaled_sh;
   logic [PW-1:0]            jx;

   assign jx = cmd.j[PW-1:0];

   always_comb begin
      if (dot_acc_ff > DACC_W'(signed'(32'h7fffffff)))
         acc_sat = 32'sh7fffffff;
      else if (dot_acc_ff < DACC_W'(signed'(32'h80000000)))
         acc_sat = 32'sh80000000;
      else
         acc_sat = dot_acc_ff[31:0];
      scaled_sh = scaled_ff[49:16];
      if (scaled_sh > 34'sh07fffffff)
         score_new = 32'sh7fffffff;
      else if (scaled_sh < -34'sh080000000)
         score_new = 32'sh80000000;
      else
         score_new = scaled_sh[31:0];
   end

   // exp path
   logic [T_W-1:0]   t_ff;
   logic [29:0]      part_ff;
   logic [EXP_W-1:0] ex_ff [SEQ_POSITIONS];
   logic [SUM_W-1:0] sum_ff;
   logic signed [32:0] diff;
   logic [49:0]      t_prod;
   logic [4:0]       lut_idx;
   logic [11:0]      frac_r;
   logic [17:0]      exp_n;
   logic [30:0]      interp;
   logic [EXP_W-1:0] m_val, e_val;

   always_comb begin
      diff    = {max_ff[31], max_ff} - {score_ff[jx][31], score_ff[jx]};
      t_prod  = 33'(unsigned'(diff)) * LOG2E_Q16;
      lut_idx = {1'b0, t_ff[15:12]};
      frac_r  = t_ff[11:0];
      exp_n   = t_ff[T_W-1:16];
      interp  = 31'(part_ff) + 31'(exp2_lut(lut_idx + 5'd1)) * 31'(frac_r) + 31'd2048;
      m_val   = interp[28:12];
      e_val   = (exp_n >= 18'd17) ? '0 : (m_val >> exp_n[4:0]);
   end

   // reciprocal: restoring divide of 2^32 by the exp sum, one bit a cycle
   logic [SUM_W:0]  rem_ff;
   logic [DIV_STEPS-1:0] quo_ff;
   logic [5:0]      div_cnt_ff;
   logic            div_busy_ff;
   logic [SUM_W:0]  rem_sh;
   logic            rem_ge;

   assign rem_sh = {rem_ff[SUM_W-1:0], (div_cnt_ff == 6'(DIV_STEPS))};
   assign rem_ge = rem_sh >= {1'b0, sum_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (cmd.step == ST_DIV_START) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= 6'(DIV_STEPS);
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff - 1'b1;
         if (div_cnt_ff == 6'd1) div_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step == ST_DIV_START) begin
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (div_busy_ff) begin
         rem_ff <= rem_ge ? (rem_sh - {1'b0, sum_ff}) : rem_sh;
         quo_ff <= {quo_ff[DIV_STEPS-2:0], rem_ge};
      end
   end

   assign status.div_done = !div_busy_ff;

   // weights and value mix
   logic [15:0]              weight_ff [SEQ_POSITIONS];
   logic signed [32:0]       mix_prod_ff;
   logic signed [MACC_W-1:0] mix_acc_ff;
   logic [33:0]              w_prod;
   logic [18:0]              w_rnd;
   logic signed [MACC_W-1:0] mix_rnd;
   logic signed [MACC_W-17:0] mix_sh;
   logic signed [ELEM_W-1:0] out_val;

   always_comb begin
      w_prod  = ex_ff[jx] * quo_ff[16:0];
      w_rnd   = 19'(w_prod[33:16]) + 19'(w_prod[15]);
      mix_rnd = mix_acc_ff + MACC_W'(32768);
      mix_sh  = mix_rnd[MACC_W-1:16];
      if (mix_sh > (MACC_W-16)'(32767))
         out_val = 16'sh7fff;
      else if (mix_sh < -(MACC_W-16)'(32768))
         out_val = 16'sh8000;
      else
         out_val = mix_sh[15:0];
   end

   always_ff @(posedge clock) begin
      case (cmd.step)
         ST_DOT_MUL: dot_prod_ff <= q_rd_ff * k_rd_ff;
         ST_DOT_ACC: dot_acc_ff  <= cmd.first ? DACC_W'(dot_prod_ff)
                                              : dot_acc_ff + DACC_W'(dot_prod_ff);
         ST_SCALE:   scaled_ff   <= 50'(acc_sat) * 50'(signed'({1'b0, INV}));
         ST_SCORE: begin
            score_ff[jx] <= score_new;
            if (cmd.first || score_new > max_ff) max_ff <= score_new;
         end
         ST_EXP_T:   t_ff    <= t_prod[49:16];
         ST_EXP_LO:  part_ff <= exp2_lut(lut_idx) * (13'd4096 - 13'(frac_r));
         ST_EXP_HI: begin
            ex_ff[jx] <= e_val;
            sum_ff    <= cmd.first ? SUM_W'(e_val) : sum_ff + SUM_W'(e_val);
         end
         ST_WGT:     weight_ff[jx] <= (w_rnd > 19'd65535) ? 16'hffff : w_rnd[15:0];
         ST_MIX_MUL: mix_prod_ff <= signed'({1'b0, weight_ff[jx]}) * v_rd_ff;
         ST_MIX_ACC: mix_acc_ff  <= cmd.first ? MACC_W'(mix_prod_ff)
                                              : mix_acc_ff + MACC_W'(mix_prod_ff);
         default: ;
      endcase
   end

   // output register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.step == ST_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step == ST_EMIT) begin
         rsp_out_row    <= ROW_W'(cmd.i);
         rsp_out_column <= COL_W'(cmd.k);
         rsp_result     <= out_val;
         rsp_last       <= cmd.last_elem;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

endmodule

// ===== sv/scaled_dot_product_attention.sv =====
// Scaled dot-product attention over small Q8.8 matrices.
// Depends on sdpa_pkg, sdpa_req_if, sdpa_rsp_if, sdpa_ctrl, sdpa_datapath.
//
// Usage:
//   req channel: command 0/1/2 loads one query/key/value element at
//   (row, column); out-of-range loads are dropped.
//   command 3 runs attention over the stored matrices; row, column and
//   element are ignored for it.
//   rsp channel: one beat per output element, row by row, column by
//   column; last marks the final element.
//   req ready is high only while the sequencer is idle; a compute holds it
//   low until the last element has been placed in the output register.
//   Per query row, a compute runs the dot products and scores, the exp
//   values, the reciprocal of the exp sum, the weights, and then the
//   value mix and emit for each feature, one feature at a time.
//   Throughput is set by the sequencer, which issues one step at a time,
//   and by the bit-serial reciprocal, which holds it until done.
//   A stalled rsp holds the output register; the next element waits in
//   the sequencer until the register frees. Reset is synchronous: it
//   idles the sequencer and empties the output register; stores keep
//   their contents, and unwritten entries read as unknown.
module scaled_dot_product_attention import sdpa_pkg::*; #(
   parameter int SEQ_POSITIONS = 4,
   parameter int FEATURE_DIM   = 5
) (
   input  logic clock,
   input  logic reset,
   sdpa_req_if.sink   req,
   sdpa_rsp_if.source rsp
);

   cmd_type    cmd;
   status_type status;

   // sequencer: one datapath step per cycle unless idle or stalled
   sdpa_ctrl #(
      .SEQ_POSITIONS (SEQ_POSITIONS),
      .FEATURE_DIM   (FEATURE_DIM)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_command (req.command),
      .req_ready   (req.ready),
      .status      (status),
      .cmd         (cmd)
   );

   // stores, arithmetic and output register
   sdpa_datapath #(
      .SEQ_POSITIONS (SEQ_POSITIONS),
      .FEATURE_DIM   (FEATURE_DIM)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_command    (req.command),
      .req_row        (req.row),
      .req_column     (req.column),
      .req_element    (req.element),
      .rsp_ready      (rsp.ready),
      .rsp_valid      (rsp.valid),
      .rsp_out_row    (rsp.out_row),
      .rsp_out_column (rsp.out_column),
      .rsp_result     (rsp.result),
      .rsp_last       (rsp.last)
   );

endmodule
